// File: rtl/gdcr_pkg.sv
package gdcr_pkg;

  localparam int PinW  = 4;
  localparam int MaskW = 8;
  localparam int HoldW = 8;
  localparam int IdxW  = 8;

  // Item operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_FORCE = 1'b1;

  // Configuration register indexes
  localparam logic [IdxW-1:0] REG_PIN_MASK      = 8'd0;
  localparam logic [IdxW-1:0] REG_HOLDOFF_TICKS = 8'd1;

  localparam logic [MaskW-1:0] PIN_MASK_RESET      = 8'hFF;
  localparam logic [HoldW-1:0] HOLDOFF_TICKS_RESET = 8'd20;

  typedef logic [PinW-1:0] pins_t;

  // Masked with the low nibble, then inverted by the high nibble.
  function automatic pins_t condition_pins(input pins_t raw, input logic [MaskW-1:0] mask);
    condition_pins = (raw & mask[PinW-1:0]) ^ mask[MaskW-1:PinW];
  endfunction

endpackage

// File: rtl/gpio_debounce_change_reporter.sv
// Channel | Direction | Handshake            | Payload
// --------+-----------+----------------------+--------------------------------
// input   | in        | in_valid / in_ready  | operation[0:0], pin_sample[3:0]
// output  | out       | out_valid / out_ready| port_state[3:0]
// config  | in        | cfg_valid / cfg_ready| cfg_index[7:0], cfg_data[7:0]
//
// One item is taken every cycle while the input register is not held; each item is
// held in the input register, and a reported item then reaches the result register.
// The throughput is set by the result register: a held result stalls the input
// register, and ticks that report nothing wait behind it too.
// Synchronous reset clears the history, slot, reported state and hold-off count,
// and loads the register defaults (mask 0xFF, hold-off 20).
// Configuration writes are always taken; cfg_ready is tied high.
module gpio_debounce_change_reporter
  import gdcr_pkg::*;
#(
  parameter int HISTORY_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             operation,
  input  logic [PinW-1:0]  pin_sample,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PinW-1:0]  port_state,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IdxW-1:0]  cfg_index,
  input  logic [MaskW-1:0] cfg_data
);

  localparam int SlotW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(HISTORY_DEPTH - 1);

  logic [MaskW-1:0] pin_mask;
  logic [HoldW-1:0] holdoff_ticks;

  logic             s1_valid;
  logic             s1_op;
  pins_t            s1_pins;

  pins_t            history [HISTORY_DEPTH];
  logic [SlotW-1:0] write_slot;
  pins_t            reported_state;
  logic [HoldW-1:0] holdoff_count;

  logic             s1_fire;
  pins_t            cond;
  logic             stable;
  logic             report;

  assign cfg_ready = 1'b1;
  assign s1_fire   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_fire;
  assign cond      = condition_pins(s1_pins, pin_mask);

  // The entry at the write slot takes the new sample, so only the others count.
  always_comb begin
    stable = 1'b1;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (SlotW'(i) != write_slot && history[i] != cond) begin
        stable = 1'b0;
      end
    end
  end

  always_comb begin
    if (s1_op == OP_FORCE) begin
      report = 1'b1;
    end else begin
      report = (holdoff_count == '0) && stable && (reported_state != cond);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_mask      <= PIN_MASK_RESET;
      holdoff_ticks <= HOLDOFF_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PIN_MASK:      pin_mask      <= cfg_data;
        REG_HOLDOFF_TICKS: holdoff_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op   <= operation;
      s1_pins <= pin_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        history[i] <= '0;
      end
      write_slot     <= '0;
      reported_state <= '0;
      holdoff_count  <= '0;
    end else if (s1_fire) begin
      if (report) begin
        reported_state <= cond;
      end
      if (s1_op == OP_TICK) begin
        history[write_slot] <= cond;
        write_slot          <= (write_slot == LastSlot) ? '0 : write_slot + 1'b1;
        if (holdoff_count != '0) begin
          holdoff_count <= holdoff_count - 1'b1;
        end else if (report) begin
          holdoff_count <= holdoff_ticks;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= report;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && report) begin
      port_state <= cond;
    end
  end

  a_report_updates_state: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && report) |=> (out_valid && reported_state == port_state))
    else $error("reported state does not follow the reported item");

  a_tick_report_loads_holdoff: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && report && s1_op == OP_TICK) |=> (holdoff_count == $past(holdoff_ticks)))
    else $error("hold-off not loaded after a change report");

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    write_slot <= LastSlot)
    else $error("history write slot out of range");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s1_valid)
    else $error("accepted item lost from the input register");

  a_held_result_stalls: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(port_state)))
    else $error("held result changed while stalled");

endmodule
